### design/wavetable_oscillator_assert.svh
// Assertion macros for the wavetable oscillator
`ifndef WAVETABLE_OSCILLATOR_ASSERT_SVH
`define WAVETABLE_OSCILLATOR_ASSERT_SVH

// checked only outside reset
`define WVO_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define WVO_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/wvo_pkg.sv
// Package: constants and state type for the wavetable oscillator
package wvo_pkg;

  localparam int TableDepth = 256;
  localparam int PhaseW     = 32;
  localparam int SampleW    = 32;
  localparam int FracW      = 20;  // interpolation fraction bits below the index
  localparam int FracShift  = 11;  // fraction placed as a Q31 weight

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RD1,
    S_MUL0,
    S_MUL1,
    S_SUM,
    S_GAIN,
    S_DONE
  } wvo_state_t;

endpackage

### design/wvo_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data
module wvo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/wavetable_oscillator.sv
// Top level: DDS wavetable oscillator with linear interpolation and gain
//
//   channel | handshake             | words
//   --------+-----------------------+-------------------------------------------
//   in      | in_valid / in_ready   | func, phase_step, gain, table_index, table_value
//   out     | out_valid / out_ready | sample, wrapped, phase_now
//
// A table write gives no word out. A tick makes two reads of the single
// table read port, then three products on one shared 33x33 multiplier,
// each registered. The phase accumulator moves when the tick is accepted.
// The output register holds a finished word while the next item runs; a
// tick waits in its last state until that register is free. Reset clears
// the phase, the sequencer and out_valid; the table is not cleared.
module wavetable_oscillator
  import wvo_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepth
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             func,
  input  logic [PhaseW-1:0]                phase_step,
  input  logic signed [SampleW-1:0]        gain,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   table_index,
  input  logic signed [SampleW-1:0]        table_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [SampleW-1:0]        sample,
  output logic                             wrapped,
  output logic [PhaseW-1:0]                phase_now
);

  `include "wavetable_oscillator_assert.svh"

  localparam int IdxW    = $clog2(TABLE_DEPTH);
  localparam int FracLsb = PhaseW - IdxW - FracW;

  wvo_state_t state, state_next;

  logic [PhaseW-1:0]         phase_acc;
  logic [PhaseW-1:0]         phase_sum;
  logic [PhaseW-1:0]         ph;
  logic                      wrap_r;
  logic signed [SampleW-1:0] gain_r;
  logic signed [SampleW-1:0] y0;
  logic signed [SampleW-1:0] y1;
  logic signed [SampleW-1:0] acc0;
  logic signed [SampleW-1:0] interp;
  logic signed [SampleW-1:0] ysum;
  logic signed [63:0]        mul_p;
  logic signed [32:0]        mul_a;
  logic signed [32:0]        mul_b;
  logic signed [65:0]        mul_full;
  logic                      mul_en;

  logic [IdxW-1:0]           idx;
  logic                      last_seg;
  logic [30:0]               frac_w;
  logic [30:0]               frac_c;

  logic                      ram_we;
  logic [IdxW-1:0]           ram_raddr;
  logic [SampleW-1:0]        ram_rdata;

  logic                      accept;
  logic                      out_free;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign phase_sum = phase_acc + phase_step;

  assign idx      = ph[PhaseW-1 -: IdxW];
  assign last_seg = (idx == IdxW'(TABLE_DEPTH - 1));
  assign frac_w   = {ph[FracLsb +: FracW], FracShift'(0)};
  assign frac_c   = 31'h7FFF_FFFF - frac_w;
  assign ysum     = acc0 + mul_p[63:32];

  wvo_ram #(
    .WIDTH(SampleW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(table_index),
    .wdata(table_value),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = idx;
    mul_en     = 1'b0;
    mul_a      = 33'(y0);
    mul_b      = {2'b00, frac_c};
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ram_we   = in_valid && func;
        if (in_valid && !func) begin
          state_next = S_RD0;
        end
      end
      S_RD0: begin
        state_next = S_RD1;
      end
      S_RD1: begin
        ram_raddr  = idx + IdxW'(1);  // unused in the last segment
        state_next = S_MUL0;
      end
      S_MUL0: begin
        mul_en     = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        mul_en     = 1'b1;
        mul_a      = 33'(y1);
        mul_b      = {2'b00, frac_w};
        state_next = S_SUM;
      end
      S_SUM: begin
        state_next = S_GAIN;
      end
      S_GAIN: begin
        mul_en     = 1'b1;
        mul_a      = 33'(gain_r);
        mul_b      = 33'(interp);
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else if (accept && !func) begin
      phase_acc <= phase_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !func) begin
      ph     <= phase_sum;
      wrap_r <= (phase_sum < phase_step);
      gain_r <= gain;
    end
    if (state == S_RD1) begin
      y0 <= ram_rdata;
    end
    if (state == S_MUL0) begin
      y1 <= ram_rdata;
    end
    if (state == S_MUL1) begin
      acc0 <= mul_p[63:32];
    end
    if (state == S_SUM) begin
      // last segment returns the last entry as is
      interp <= last_seg ? y0 : {ysum[30:0], 1'b0};
    end
    if (mul_en) begin
      mul_p <= mul_full[63:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      sample    <= mul_p[62:31];
      wrapped   <= wrap_r;
      phase_now <= ph;
    end
  end

  `WVO_ASSERT(a_tick_starts_read, (accept && !func) |=> (state == S_RD0), "tick did not start table read")
  `WVO_ASSERT(a_write_holds_phase, (accept && func) |=> $stable(phase_acc), "table write moved the phase")
  `WVO_ASSERT(a_out_from_done, $rose(out_valid) |-> ($past(state) == S_DONE), "output word not from final state")
  `WVO_ASSERT(a_done_waits, (state == S_DONE && !out_free) |=> (state == S_DONE), "tick left final state while output full")
  `WVO_ASSERT_ALWAYS(a_reset_clears, rst |=> (!out_valid && state == S_IDLE), "reset did not clear control")

endmodule
